[sv/modbus_rtu_response_sniffer_assert.svh]
// Assertion macros shared by the sniffer RTL.
`ifndef MODBUS_RTU_RESPONSE_SNIFFER_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_SNIFFER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mrs assertion failed");

// Next-cycle implication, checked outside reset.
`define MRS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mrs assertion failed");

`endif

[sv/mrs_pkg.sv]
// Package: frame constants, status codes and CRC helpers for the Modbus RTU sniffer.
`timescale 1ns / 1ps

package mrs_pkg;

    localparam int unsigned FRAME_BYTES = 39;
    localparam int unsigned KEPT_WORDS  = 9;
    localparam int unsigned WORD_W      = 16;

    localparam logic [5:0]  CRC_SPAN    = 6'd37;
    localparam logic [5:0]  HDR_BYTES   = 6'd3;
    localparam logic [5:0]  LAST_IDX    = 6'(FRAME_BYTES - 1);
    localparam logic [7:0]  HDR_FUNC    = 8'h03;
    localparam logic [7:0]  HDR_COUNT   = 8'h22;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  MAX_ID_RST  = 8'd16;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_ID_RANGE = 2'd2
    } t_status;

    typedef logic [WORD_W-1:0] t_word;

    // Modbus CRC-16, one byte, reflected.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Register word number -> kept slot + 1, zero when the word is dropped.
    function automatic logic [3:0] word_slot(input logic [4:0] w);
        logic [3:0] s;
        case (w)
            5'd0:    s = 4'd1;
            5'd2:    s = 4'd2;
            5'd3:    s = 4'd3;
            5'd4:    s = 4'd4;
            5'd5:    s = 4'd5;
            5'd7:    s = 4'd6;
            5'd8:    s = 4'd7;
            5'd13:   s = 4'd8;
            5'd14:   s = 4'd9;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

[sv/modbus_rtu_response_sniffer.sv]
// Top level: Modbus RTU battery response sniffer with CRC check and register decode.
`timescale 1ns / 1ps
`include "modbus_rtu_response_sniffer_assert.svh"

// Takes one bus byte per clock on the slave stream and hunts for a read response
// header (nonzero slave id, 0x03, 0x22). The 39-byte frame is then collected, the
// Modbus CRC-16 runs over the first 37 bytes one byte per cycle, and on the last
// byte one result transfer is registered and offered on the master stream the
// next cycle. The single CRC byte update (eight shift/xor steps) sets the timing
// path for each byte. The input stalls only while a result waits in
// the output register and the sink holds tready low. A result whose CRC fails
// (status 1) or whose slave id is zero or above the highest accepted slave address
// (status 2) carries the slave id and all register fields zero. Writing i_cfg_we
// loads the highest accepted slave address; do so only while no frame is in progress.
module modbus_rtu_response_sniffer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,     // highest accepted slave address
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,       // [7:0] rx_byte
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [1:0] status, [9:2] slave_addr, [25:10] charge_cycles, [41:26] state_of_charge,
    // [57:42] pack_voltage, [73:58] pack_current, [89:74] temperature,
    // [105:90] charge_current_limit, [121:106] discharge_current_limit,
    // [137:122] state_of_health, [153:138] charge_voltage_limit, [159:154] zero
    output logic [159:0] o_m_tdata
);

    logic [7:0]  r_max_id;
    logic        r_collecting, n_collecting;
    logic [15:0] r_hist, n_hist;
    logic [5:0]  r_idx, n_idx;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_crc1, n_crc1;   // CRC of the newest history byte alone
    logic [15:0] r_crc2, n_crc2;   // CRC of both history bytes
    logic [7:0]  r_slave, n_slave;
    logic [7:0]  r_hold, n_hold;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic        r_out_valid, n_out_valid;

    mrs_pkg::t_word   r_words [mrs_pkg::KEPT_WORDS];
    mrs_pkg::t_word   r_out_words [mrs_pkg::KEPT_WORDS];
    mrs_pkg::t_status r_status, n_status;
    logic [7:0]       r_out_slave;

    logic        in_xfer;
    logic        emit;
    logic        word_we;
    logic [3:0]  word_sel;
    logic [4:0]  word_num;
    logic [3:0]  slot1;
    logic [15:0] rx_crc;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;

    assign word_num = 5'(r_idx[5:1] - 5'd2);
    assign slot1    = mrs_pkg::word_slot(word_num);
    assign word_sel = 4'(slot1 - 4'd1);
    assign rx_crc   = {i_s_tdata, r_crc_lo};

    always_comb begin
        n_collecting = r_collecting;
        n_hist       = r_hist;
        n_idx        = r_idx;
        n_crc        = r_crc;
        n_crc1       = r_crc1;
        n_crc2       = r_crc2;
        n_slave      = r_slave;
        n_hold       = r_hold;
        n_crc_lo     = r_crc_lo;
        n_status     = mrs_pkg::ST_OK;
        word_we      = 1'b0;
        emit         = 1'b0;
        n_out_valid  = r_out_valid && !i_m_tready;

        if (in_xfer) begin
            if (!r_collecting) begin
                n_crc1 = mrs_pkg::crc_byte(mrs_pkg::CRC_INIT, i_s_tdata);
                n_crc2 = mrs_pkg::crc_byte(r_crc1, i_s_tdata);
                if (r_hist[15:8] != 8'd0 && r_hist[7:0] == mrs_pkg::HDR_FUNC &&
                    i_s_tdata == mrs_pkg::HDR_COUNT) begin
                    n_crc        = mrs_pkg::crc_byte(r_crc2, i_s_tdata);
                    n_slave      = r_hist[15:8];
                    n_idx        = mrs_pkg::HDR_BYTES;
                    n_collecting = 1'b1;
                end else begin
                    n_hist = {r_hist[7:0], i_s_tdata};
                end
            end else if (r_idx < mrs_pkg::CRC_SPAN) begin
                n_crc = mrs_pkg::crc_byte(r_crc, i_s_tdata);
                if (r_idx[0]) begin
                    n_hold = i_s_tdata;     // high byte of a register word
                end else begin
                    word_we = (slot1 != 4'd0);
                end
                n_idx = 6'(r_idx + 6'd1);
            end else if (r_idx == mrs_pkg::CRC_SPAN) begin
                n_crc_lo = i_s_tdata;
                n_idx    = 6'(r_idx + 6'd1);
            end else begin
                if (rx_crc != r_crc) begin
                    n_status = mrs_pkg::ST_CRC_ERR;
                end else if (r_slave == 8'd0 || r_slave > r_max_id) begin
                    n_status = mrs_pkg::ST_ID_RANGE;
                end else begin
                    n_status = mrs_pkg::ST_OK;
                end
                emit         = 1'b1;
                n_out_valid  = 1'b1;
                n_collecting = 1'b0;
                n_hist       = 16'd0;
                n_idx        = 6'd0;
                n_crc        = mrs_pkg::CRC_INIT;
                n_crc1       = mrs_pkg::CRC_INIT;
                n_crc2       = mrs_pkg::CRC_INIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_id     <= mrs_pkg::MAX_ID_RST;
            r_collecting <= 1'b0;
            r_hist       <= 16'd0;
            r_idx        <= 6'd0;
            r_crc        <= mrs_pkg::CRC_INIT;
            r_crc1       <= mrs_pkg::CRC_INIT;
            r_crc2       <= mrs_pkg::CRC_INIT;
            r_slave      <= 8'd0;
            r_hold       <= 8'd0;
            r_crc_lo     <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_id <= i_cfg_wdata;
            end
            r_collecting <= n_collecting;
            r_hist       <= n_hist;
            r_idx        <= n_idx;
            r_crc        <= n_crc;
            r_crc1       <= n_crc1;
            r_crc2       <= n_crc2;
            r_slave      <= n_slave;
            r_hold       <= n_hold;
            r_crc_lo     <= n_crc_lo;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload storage, no reset needed.
    always_ff @(posedge i_clk) begin
        if (word_we) begin
            r_words[word_sel] <= {r_hold, i_s_tdata};
        end
        if (emit) begin
            r_status    <= n_status;
            r_out_slave <= r_slave;
            for (int j = 0; j < mrs_pkg::KEPT_WORDS; j++) begin
                r_out_words[j] <= (n_status == mrs_pkg::ST_OK) ? r_words[j] : '0;
            end
        end
    end

    assign o_m_tdata = {6'd0,
                        r_out_words[8], r_out_words[7], r_out_words[6],
                        r_out_words[5], r_out_words[4], r_out_words[3],
                        r_out_words[2], r_out_words[1], r_out_words[0],
                        r_out_slave, r_status};

    `MRS_ASSERT_IMP(a_hunt_idx_zero, i_clk, i_rst_n, !r_collecting, r_idx == 6'd0)
    `MRS_ASSERT_IMP(a_idx_in_frame, i_clk, i_rst_n, r_collecting,
        (r_idx >= mrs_pkg::HDR_BYTES) && (r_idx <= mrs_pkg::LAST_IDX))
    `MRS_ASSERT_NXT(a_last_byte_emits, i_clk, i_rst_n,
        in_xfer && r_collecting && r_idx == mrs_pkg::LAST_IDX, r_out_valid && !r_collecting)
    `MRS_ASSERT_IMP(a_bad_frame_zeroed, i_clk, i_rst_n,
        r_out_valid && r_status != mrs_pkg::ST_OK, o_m_tdata[159:10] == '0)

endmodule
